// File: src/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants of the LED flash sequencer
// Event codes, field widths, request and result structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

  localparam int TICK_BITS  = 16;
  localparam int COUNT_BITS = 8;

  localparam int KIND_W   = 3;
  localparam int LEVEL_W  = 8;
  localparam int LENGTH_W = 16;
  localparam int FLASH_W  = 8;

  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_START  = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_SET    = 3'd3,
    KIND_OFF    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    color_t              color;
    logic [LENGTH_W-1:0] on_ticks;
    logic [LENGTH_W-1:0] off_ticks;
    logic [FLASH_W-1:0]  flash_count;
  } request_t;

  typedef struct packed {
    color_t color;
    logic   busy;
  } result_t;

endpackage

`default_nettype wire

// File: src/lfs_core.sv
// ----------------------------------------------------------------------------
// lfs_core: flash sequencer state and event update
// Holds the sequencer state and applies one request per step; presents the
// post-update color and busy flag combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfs_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire lfs_pkg::request_t req,
  output lfs_pkg::result_t       res_nxt
);

  logic              active_r, active_nxt;
  logic              lit_phase_r, lit_phase_nxt;
  lfs_pkg::tick_t    ticks_left_r, ticks_left_nxt;
  lfs_pkg::count_t   pulses_done_r, pulses_done_nxt;
  lfs_pkg::count_t   pulses_wanted_r, pulses_wanted_nxt;
  lfs_pkg::tick_t    on_length_r, on_length_nxt;
  lfs_pkg::tick_t    off_length_r, off_length_nxt;
  lfs_pkg::color_t   flash_color_r, flash_color_nxt;
  lfs_pkg::color_t   shown_color_r, shown_color_nxt;

  lfs_pkg::count_t   done_inc;
  logic              more_after_on;
  logic              more_now;

  assign done_inc      = lfs_pkg::count_t'(pulses_done_r + 1'b1);
  assign more_after_on = (pulses_wanted_r == '0) || (done_inc < pulses_wanted_r);
  assign more_now      = (pulses_wanted_r == '0) || (pulses_done_r < pulses_wanted_r);

  always_comb begin
    active_nxt        = active_r;
    lit_phase_nxt     = lit_phase_r;
    ticks_left_nxt    = ticks_left_r;
    pulses_done_nxt   = pulses_done_r;
    pulses_wanted_nxt = pulses_wanted_r;
    on_length_nxt     = on_length_r;
    off_length_nxt    = off_length_r;
    flash_color_nxt   = flash_color_r;
    shown_color_nxt   = shown_color_r;
    case (req.kind)
      lfs_pkg::KIND_TICK: begin
        if (active_r) begin
          if (ticks_left_r <= lfs_pkg::tick_t'(1)) begin
            if (lit_phase_r) begin
              // end of on pulse
              shown_color_nxt = '0;
              lit_phase_nxt   = 1'b0;
              pulses_done_nxt = done_inc;
              if (more_after_on) begin
                ticks_left_nxt = off_length_r;
              end else begin
                active_nxt        = 1'b0;
                pulses_done_nxt   = '0;
                pulses_wanted_nxt = '0;
                ticks_left_nxt    = '0;
              end
            end else begin
              // end of dark gap
              lit_phase_nxt = 1'b1;
              if (more_now) begin
                shown_color_nxt = flash_color_r;
                ticks_left_nxt  = on_length_r;
              end else begin
                active_nxt     = 1'b0;
                ticks_left_nxt = '0;
              end
            end
          end else begin
            ticks_left_nxt = ticks_left_r - 1'b1;
          end
        end
      end
      lfs_pkg::KIND_START: begin
        on_length_nxt     = lfs_pkg::tick_t'(req.on_ticks);
        off_length_nxt    = lfs_pkg::tick_t'(req.off_ticks);
        pulses_wanted_nxt = lfs_pkg::count_t'(req.flash_count);
        pulses_done_nxt   = '0;
        flash_color_nxt   = req.color;
        shown_color_nxt   = req.color;
        lit_phase_nxt     = 1'b1;
        ticks_left_nxt    = lfs_pkg::tick_t'(req.on_ticks);
        active_nxt        = (lfs_pkg::tick_t'(req.on_ticks) != '0);
      end
      lfs_pkg::KIND_CANCEL: begin
        active_nxt      = 1'b0;
        shown_color_nxt = '0;
      end
      lfs_pkg::KIND_SET: begin
        shown_color_nxt = req.color;
      end
      lfs_pkg::KIND_OFF: begin
        if (!active_r) begin
          shown_color_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_nxt.color = shown_color_nxt;
  assign res_nxt.busy  = active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      lit_phase_r     <= 1'b0;
      ticks_left_r    <= '0;
      pulses_done_r   <= '0;
      pulses_wanted_r <= '0;
      on_length_r     <= '0;
      off_length_r    <= '0;
      flash_color_r   <= '0;
      shown_color_r   <= '0;
    end else if (step) begin
      active_r        <= active_nxt;
      lit_phase_r     <= lit_phase_nxt;
      ticks_left_r    <= ticks_left_nxt;
      pulses_done_r   <= pulses_done_nxt;
      pulses_wanted_r <= pulses_wanted_nxt;
      on_length_r     <= on_length_nxt;
      off_length_r    <= off_length_nxt;
      flash_color_r   <= flash_color_nxt;
      shown_color_r   <= shown_color_nxt;
    end
  end

  // a counted sequence never runs past its pulse count
  a_pulses_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && pulses_wanted_r != '0) |-> (pulses_done_r < pulses_wanted_r))
    else $error("pulse count exceeded while busy");

  // cancel always leaves the sequencer idle and dark
  a_cancel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && req.kind == lfs_pkg::KIND_CANCEL) |=> (!active_r && shown_color_r == '0))
    else $error("cancel did not stop the sequence");

  // ticks while idle leave the driven color alone
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (step && req.kind == lfs_pkg::KIND_TICK && !active_r) |=> $stable(shown_color_r))
    else $error("idle tick changed the color");

  // a start with a nonzero on length begins lit and busy
  a_start_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && req.kind == lfs_pkg::KIND_START && req.on_ticks != '0)
      |=> (active_r && lit_phase_r))
    else $error("start did not begin a lit pulse");

endmodule

`default_nettype wire

// File: src/led_flash_sequencer.sv
// ----------------------------------------------------------------------------
// led_flash_sequencer: RGB indicator flash sequencer
// Takes one event request at a time and returns the driven color and busy
// flag after that event.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in_      | in_valid / in_ready  | kind, red/green/blue level, on/off ticks,
//           |                      | flash count
//  out_     | out_valid / out_ready| red/green/blue out, busy
//
//  one request per cycle sustained while out_ready is high; out_valid rises
//  once a request passes the input register, then the result register
//  the state update happens as a request moves into the result register
//  rst_n clears all sequencer state: idle, LED dark, no result pending
//  a held result stalls the input register; a new request is still taken in
//  the cycle the held result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_flash_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_red_level,
  input  wire logic [7:0]  in_green_level,
  input  wire logic [7:0]  in_blue_level,
  input  wire logic [15:0] in_on_ticks,
  input  wire logic [15:0] in_off_ticks,
  input  wire logic [7:0]  in_flash_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_busy_res
);

  logic              req_vld_r;
  lfs_pkg::request_t req_r;
  logic              res_vld_r;
  lfs_pkg::result_t  res_r;
  lfs_pkg::result_t  res_nxt;
  logic              advance;

  assign advance  = req_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.kind        <= in_kind;
      req_r.color.red   <= in_red_level;
      req_r.color.green <= in_green_level;
      req_r.color.blue  <= in_blue_level;
      req_r.on_ticks    <= in_on_ticks;
      req_r.off_ticks   <= in_off_ticks;
      req_r.flash_count <= in_flash_count;
    end
  end

  lfs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .req     (req_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = res_vld_r;
  assign out_red_out   = res_r.color.red;
  assign out_green_out = res_r.color.green;
  assign out_blue_out  = res_r.color.blue;
  assign out_busy_res  = res_r.busy;

endmodule

`default_nettype wire
